// ----- hdl/ultrasonic_echo_range_averager_macros.svh -----
// Assertion macros shared by the ultrasonic echo range averager RTL.
`ifndef ULTRASONIC_ECHO_RANGE_AVERAGER_MACROS_SVH
`define ULTRASONIC_ECHO_RANGE_AVERAGER_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define UERA_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define UERA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- hdl/uera_pkg.sv -----
// Package with types, constants and helpers of the ultrasonic echo range averager.
package uera_pkg;

	localparam int unsigned CHANNELS_DEF   = 3;
	localparam int unsigned MAX_WINDOW_DEF = 16;
	localparam int unsigned QUEUE_DEPTH    = 4;

	localparam int unsigned CH_W   = 3;
	localparam int unsigned TS_W   = 32;
	localparam int unsigned DIST_W = 16;
	localparam int unsigned WIN_W  = 5;

	localparam logic [DIST_W-1:0] FULL_RANGE_Q8 = 16'd51200;
	localparam logic [WIN_W-1:0]  WINDOW_RESET  = 5'd5;

	// Distance = floor(diff * 2744 / 625); any diff at or above the limit saturates
	localparam int unsigned       DIFF_W     = 14;
	localparam logic [TS_W-1:0]   DIFF_SAT   = 32'd11663;
	localparam int unsigned       DIST_MUL_W = 12;
	localparam logic [DIST_MUL_W-1:0] DIST_MUL = 12'd2744;

	// Below the limit the distance is (diff * DIST_RECIP) >> DIST_SHIFT, exact for every diff
	// up to 11662 since DIST_RECIP = ceil(2744 * 2^24 / 625)
	localparam int unsigned          RECIP_W    = 27;
	localparam int unsigned          DIST_SHIFT = 24;
	localparam logic [RECIP_W-1:0]   DIST_RECIP = 27'd73658690;
	localparam int unsigned          PROD_W     = DIFF_W + RECIP_W;

	// Serial divider widths
	localparam int unsigned DIV_N_W   = 25;
	localparam int unsigned DIV_D_W   = 10;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_N_W + 1);
	localparam logic [DIV_D_W-1:0] DIST_DIV = 10'd625;

	typedef struct packed {
		logic              command;
		logic [CH_W-1:0]   channel;
		logic              rising;
		logic [TS_W-1:0]   timestamp_us;
	} in_item_t;

	typedef struct packed {
		logic [CH_W-1:0]   out_channel;
		logic [DIST_W-1:0] avg_distance_q8;
		logic              was_fresh;
		logic              last;
	} out_item_t;

	typedef enum logic [1:0] {
		OP_RISE,
		OP_FALL,
		OP_TICK
	} op_t;

	typedef struct packed {
		op_t             op;
		logic [CH_W-1:0] ch;
		logic [TS_W-1:0] ts;
	} cmd_t;

	typedef struct packed {
		logic               start;
		logic [DIV_N_W-1:0] dividend;
		logic [DIV_D_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [DIV_N_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIST,
		BK_RD,
		BK_UPD,
		BK_AVG,
		BK_OUT
	} back_state_t;

	// Index width for a count of n entries, at least one bit
	function automatic int unsigned width_of(input int unsigned n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage

// ----- hdl/uera_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module uera_ram
	import uera_pkg::*;
#(
	parameter int unsigned WIDTH = DIST_W,
	parameter int unsigned DEPTH = CHANNELS_DEF * MAX_WINDOW_DEF,
	localparam int unsigned ADDR_W = width_of(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one entry, register one read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hdl/uera_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
module uera_div
	import uera_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_D_W-1:0]   rem_q;
	logic [DIV_N_W-1:0]   quo_q;
	logic [DIV_D_W-1:0]   dvs_q;

	logic [DIV_D_W:0]     shifted;
	logic [DIV_D_W:0]     trial;
	logic                 ge;

	// Trial subtract of the divisor from the shifted remainder
	always_comb begin
		shifted = {rem_q, quo_q[DIV_N_W-1]};
		trial   = shifted - {1'b0, dvs_q};
		ge      = (shifted >= {1'b0, dvs_q});
	end

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_N_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift the dividend through and collect quotient bits
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? trial[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
			quo_q <= {quo_q[DIV_N_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ----- hdl/uera_fifo.sv -----
// Short command queue between the front and back parts.
module uera_fifo
	import uera_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output cmd_t pop_data,
	output logic empty
);

	localparam int unsigned PTR_W = width_of(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Store the pushed command
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- hdl/uera_front.sv -----
// Front part: accepts input transactions, classifies them and feeds the queue.
module uera_front
	import uera_pkg::*;
#(
	parameter int unsigned CHANNELS = CHANNELS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_data,
	output logic     push,
	output cmd_t     push_data,
	input  logic     full
);

	logic valid_s1;
	cmd_t cmd_s1;
	logic accept;
	logic keep;
	cmd_t cmd;

	assign in_ready  = !valid_s1 || !full;
	assign accept    = in_valid && in_ready;
	assign push      = valid_s1;
	assign push_data = cmd_s1;

	// Classify: tick, rising or falling edge; drop edges of absent channels
	always_comb begin
		cmd.ch = in_data.channel;
		cmd.ts = in_data.timestamp_us;
		keep   = 1'b1;
		if (in_data.command) begin
			cmd.op = OP_TICK;
		end else begin
			cmd.op = in_data.rising ? OP_RISE : OP_FALL;
			keep   = (32'(in_data.channel) < 32'(CHANNELS));
		end
	end

	// Hold one classified command until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= keep;
		end else if (!full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
		end
	end

endmodule

// ----- hdl/uera_back.sv -----
// Back part: per-channel echo state, moving-average rings and result output.
module uera_back
	import uera_pkg::*;
#(
	parameter int unsigned CHANNELS   = CHANNELS_DEF,
	parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [WIN_W-1:0] cfg_wdata,
	output logic             pop,
	input  cmd_t             head,
	input  logic             empty,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_data
);

	localparam int unsigned CH_IDX_W  = width_of(CHANNELS);
	localparam int unsigned CNT_W     = $clog2(MAX_WINDOW + 1);
	localparam int unsigned PTR_W     = width_of(MAX_WINDOW);
	localparam int unsigned SUM_W     = DIST_W + CNT_W;
	localparam int unsigned RAM_DEPTH = CHANNELS * MAX_WINDOW;
	localparam int unsigned ADDR_W    = width_of(RAM_DEPTH);

	back_state_t state_q, state_d;

	logic [CH_IDX_W-1:0] ch_q;
	logic [TS_W-1:0]     pulse_start_q [CHANNELS];
	logic [DIST_W-1:0]   latest_q      [CHANNELS];
	logic [CHANNELS-1:0] fresh_q;
	logic [CNT_W-1:0]    count_q       [CHANNELS];
	logic [PTR_W-1:0]    ptr_q         [CHANNELS];
	logic [SUM_W-1:0]    sum_q         [CHANNELS];
	logic [WIN_W-1:0]    window_q;
	logic [PROD_W-1:0]   prod_s1;
	logic [DIST_W-1:0]   val_q;
	logic                val_fresh_q;
	logic [DIST_W-1:0]   avg_q;
	logic                out_valid_q;
	out_item_t           out_data_q;

	logic [CH_IDX_W-1:0] head_ch;
	logic [TS_W-1:0]     diff;
	logic                sat;
	logic [CNT_W-1:0]    w_eff;
	logic [CNT_W-1:0]    p_eff;
	logic [CNT_W-1:0]    p_inc;
	logic [CNT_W-1:0]    p_next;
	logic                ring_full;
	logic [CNT_W-1:0]    cnt_new;
	logic [SUM_W-1:0]    sum_new;
	logic                last_ch;
	logic                out_free;

	logic                ram_we;
	logic [ADDR_W-1:0]   ram_addr;
	logic [DIST_W-1:0]   ram_rdata;

	div_req_t            div_req;
	div_rsp_t            div_rsp;

	// Echo edge arithmetic on the queue head
	assign head_ch = head.ch[CH_IDX_W-1:0];
	assign diff    = head.ts - pulse_start_q[head_ch];
	assign sat     = (diff >= DIFF_SAT);

	// Clamp the window to one through the ring size
	always_comb begin
		if (window_q == '0) begin
			w_eff = CNT_W'(1);
		end else if (32'(window_q) > 32'(MAX_WINDOW)) begin
			w_eff = CNT_W'(MAX_WINDOW);
		end else begin
			w_eff = CNT_W'(window_q);
		end
	end

	// Ring pointer, occupancy and running sum update for the current channel
	always_comb begin
		p_eff     = (CNT_W'(ptr_q[ch_q]) >= w_eff) ? '0 : CNT_W'(ptr_q[ch_q]);
		p_inc     = p_eff + 1'b1;
		p_next    = (p_inc >= w_eff) ? '0 : p_inc;
		ring_full = (count_q[ch_q] >= w_eff);
		cnt_new   = ring_full ? count_q[ch_q] : count_q[ch_q] + 1'b1;
		if (ring_full) begin
			sum_new = sum_q[ch_q] + SUM_W'(val_q) - SUM_W'(ram_rdata);
		end else begin
			sum_new = sum_q[ch_q] + SUM_W'(val_q);
		end
		ram_addr  = ADDR_W'(ch_q) * ADDR_W'(MAX_WINDOW) + ADDR_W'(p_eff);
	end

	assign ram_we   = (state_q == BK_UPD);
	assign last_ch  = (ch_q == CH_IDX_W'(CHANNELS - 1));
	assign out_free = !out_valid_q || out_ready;
	assign pop      = (state_q == BK_IDLE) && !empty;

	// Divider request: ring average
	always_comb begin
		div_req.start    = (state_q == BK_UPD);
		div_req.dividend = DIV_N_W'(sum_new);
		div_req.divisor  = DIV_D_W'(cnt_new);
	end

	uera_ram #(
		.WIDTH(DIST_W),
		.DEPTH(RAM_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_addr),
		.wdata(val_q),
		.raddr(ram_addr),
		.rdata(ram_rdata)
	);

	uera_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!empty) begin
					unique case (head.op)
						OP_FALL: state_d = sat ? BK_IDLE : BK_DIST;
						OP_TICK: state_d = BK_RD;
						default: state_d = BK_IDLE;
					endcase
				end
			end
			BK_DIST: state_d = BK_IDLE;
			BK_RD:   state_d = BK_UPD;
			BK_UPD:  state_d = BK_AVG;
			BK_AVG:  state_d = div_rsp.done ? BK_OUT : BK_AVG;
			BK_OUT: begin
				if (out_free) begin
					state_d = last_ch ? BK_IDLE : BK_RD;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// Per-channel state, window register and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q        <= '0;
			fresh_q     <= '0;
			window_q    <= WINDOW_RESET;
			out_valid_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				pulse_start_q[i] <= '0;
				latest_q[i]      <= FULL_RANGE_Q8;
				count_q[i]       <= '0;
				ptr_q[i]         <= '0;
				sum_q[i]         <= '0;
			end
		end else begin
			// Drain the output register, refill from the last stage
			if (state_q == BK_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				BK_IDLE: begin
					if (!empty) begin
						unique case (head.op)
							OP_RISE: pulse_start_q[head_ch] <= head.ts;
							OP_FALL: begin
								ch_q <= head_ch;
								if (sat) begin
									latest_q[head_ch] <= FULL_RANGE_Q8;
									fresh_q[head_ch]  <= 1'b1;
								end
							end
							OP_TICK: ch_q <= '0;
							default: ;
						endcase
					end
				end
				BK_DIST: begin
					latest_q[ch_q] <= prod_s1[DIST_SHIFT +: DIST_W];
					fresh_q[ch_q]  <= 1'b1;
				end
				BK_RD: fresh_q[ch_q] <= 1'b0;
				BK_UPD: begin
					count_q[ch_q] <= cnt_new;
					sum_q[ch_q]   <= sum_new;
					ptr_q[ch_q]   <= PTR_W'(p_next);
				end
				BK_OUT: begin
					if (out_free && !last_ch) begin
						ch_q <= ch_q + 1'b1;
					end
				end
				default: ;
			endcase

			// Window write restarts every history
			if (cfg_we) begin
				window_q <= cfg_wdata;
				for (int i = 0; i < CHANNELS; i++) begin
					count_q[i] <= '0;
					ptr_q[i]   <= '0;
					sum_q[i]   <= '0;
				end
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		// Scale the pulse width by the reciprocal constant
		if (state_q == BK_IDLE) begin
			prod_s1 <= PROD_W'(diff[DIFF_W-1:0]) * PROD_W'(DIST_RECIP);
		end
		if (state_q == BK_RD) begin
			val_q       <= fresh_q[ch_q] ? latest_q[ch_q] : FULL_RANGE_Q8;
			val_fresh_q <= fresh_q[ch_q];
		end
		if (state_q == BK_AVG && div_rsp.done) begin
			avg_q <= div_rsp.quotient[DIST_W-1:0];
		end
		if (state_q == BK_OUT && out_free) begin
			out_data_q.out_channel     <= CH_W'(ch_q);
			out_data_q.avg_distance_q8 <= avg_q;
			out_data_q.was_fresh       <= val_fresh_q;
			out_data_q.last            <= last_ch;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ----- hdl/ultrasonic_echo_range_averager.sv -----
// Top level of the multi-channel ultrasonic echo range averager.
// A rising echo edge stores the channel's pulse start; a falling edge turns the wrapped
// time difference into a distance in 1/256 cm (saturating at 200 cm) and latches it as a
// fresh reading; a sample tick emits one averaged result per channel in channel order,
// with last set on the highest channel. The front stage takes one transaction per cycle
// into a four-entry queue, so input stalls only when the queue is full. The back part
// works on one queued command at a time: a rising or saturating falling edge needs only
// the idle state; other falling edges also visit the distance state, which latches the
// reading from the constant reciprocal multiply made in idle; a tick steps each channel
// through the read, update, average and output states, waiting on any output stall. The
// restoring divider forms each ring average, one quotient bit per cycle over 25 bits. A
// window_length write clears every channel's history; no clearing pass runs after reset.
module ultrasonic_echo_range_averager
	import uera_pkg::*;
#(
	parameter int unsigned CHANNELS   = CHANNELS_DEF,
	parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_data,
	input  logic             cfg_we,
	input  logic [WIN_W-1:0] cfg_wdata
);

`include "ultrasonic_echo_range_averager_macros.svh"

	logic q_push;
	cmd_t q_push_data;
	logic q_full;
	logic q_pop;
	cmd_t q_pop_data;
	logic q_empty;

	uera_front #(
		.CHANNELS(CHANNELS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.push     (q_push),
		.push_data(q_push_data),
		.full     (q_full)
	);

	uera_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_push_data),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data (q_pop_data),
		.empty    (q_empty)
	);

	uera_back #(
		.CHANNELS  (CHANNELS),
		.MAX_WINDOW(MAX_WINDOW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.pop      (q_pop),
		.head     (q_pop_data),
		.empty    (q_empty),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// The final result of a tick belongs to the highest channel
	`UERA_ASSERT_IMPLIES(a_last_on_top_channel, clk, arst_n, out_valid && out_data.last, out_data.out_channel == 3'(CHANNELS - 1), "last flag on a channel other than the highest")

	// An average never exceeds full range
	`UERA_ASSERT_IMPLIES(a_avg_in_range, clk, arst_n, out_valid, out_data.avg_distance_q8 <= FULL_RANGE_Q8, "average distance above 200 cm")

	// The queue is never reported full and empty at once
	`UERA_ASSERT_ALWAYS(a_queue_consistent, clk, arst_n, !(q_full && q_empty), "queue full and empty together")

endmodule
